// ----- rtl/ssf_pkg.sv -----
// Shared types and constants of the frame sorter.
package ssf_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int DEPTH_DEFAULT = 16;

   // One value moving between cells, or one cell's stored content.
   typedef struct packed {
      logic                          valid;
      logic signed [VALUE_WIDTH-1:0] value;
   } link_type;

   // Frame phases of the sequencer.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/ssf_req_if.sv -----
// Input channel of the frame sorter: one element per transfer.
interface ssf_req_if import ssf_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic                          frame_end;

   modport source (output valid, output value, output frame_end, input ready);
   modport sink   (input valid, input value, input frame_end, output ready);
endinterface

// ----- rtl/ssf_rsp_if.sv -----
// Result channel of the frame sorter: one sorted element per transfer.
interface ssf_rsp_if import ssf_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] sorted_value;
   logic                          last_out;
   logic                          overflowed;

   modport source (output valid, output sorted_value, output last_out,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input last_out,
                   input overflowed, output ready);
endinterface

// ----- rtl/ssf_cell.sv -----
// One cell of the systolic insertion chain: keeps the smaller value, passes the larger.
module ssf_cell import ssf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     shift,
   input  link_type ins_in,
   input  link_type nbr_in,
   output link_type pass_out,
   output link_type hold_out
);

   link_type hold_ff, hold_in;
   link_type pass_ff, pass_in;

   // Insert while loading, or take the right neighbor's content while emitting.
   always_comb begin
      hold_in = hold_ff;
      pass_in = '0;
      if (shift) begin
         hold_in = nbr_in;
      end else if (ins_in.valid) begin
         if (!hold_ff.valid) begin
            hold_in = ins_in;
         end else if (ins_in.value < hold_ff.value) begin
            hold_in = ins_in;
            pass_in = hold_ff;
         end else begin
            pass_in = ins_in;
         end
      end
   end

   // Occupancy and hand-off valid bits are control state; values need no reset.
   always_ff @(posedge clock) begin
      hold_ff.value <= hold_in.value;
      pass_ff.value <= pass_in.value;
      if (reset) begin
         hold_ff.valid <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         hold_ff.valid <= hold_in.valid;
         pass_ff.valid <= pass_in.valid;
      end
   end

   assign pass_out = pass_ff;
   assign hold_out = hold_ff;

endmodule

// ----- rtl/selection_sort_frame_top.sv -----
// Top level of the frame sorter: cell chain and frame sequencer.
//
//   channel | direction | fields
//   req     | in        | value[31:0] signed, frame_end
//   rsp     | out       | sorted_value[31:0] signed, last_out, overflowed
//
// Loading takes one element per cycle; each element ripples one cell per cycle.
// After the closing element the chain settles in the drain state, which lets the
// cell-to-cell hand-off finish, and then gives one sorted element per cycle
// while the receiver is ready.
// Reset is synchronous and empties the chain. The output stalls by holding
// the chain; input is not taken while a frame is settling or being emitted.
module selection_sort_frame_top import ssf_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   ssf_req_if.sink   req,
   ssf_rsp_if.source rsp
);

   localparam int CW = $clog2(DEPTH + 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] drain_ff, drain_in;
   logic          ovf_ff, ovf_in;

   logic     req_xfer;
   logic     rsp_xfer;
   logic     shift;
   link_type inject;

   link_type ins_link  [DEPTH+1];
   link_type hold_link [DEPTH+1];

   assign req_xfer = req.valid && req.ready;
   assign rsp_xfer = rsp.valid && rsp.ready;
   assign shift    = rsp_xfer;

   // Elements beyond the store's depth are dropped at the head of the chain.
   always_comb begin
      inject.valid = req_xfer && (count_ff < CW'(DEPTH));
      inject.value = req.value;
   end

   assign ins_link[0]      = inject;
   assign hold_link[DEPTH] = '0;

   // Row of identical cells; each hands off to its right neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ssf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .ins_in   (ins_link[i]),
         .nbr_in   (hold_link[i+1]),
         .pass_out (ins_link[i+1]),
         .hold_out (hold_link[i])
      );
   end

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drain_in = drain_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (count_ff < CW'(DEPTH)) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req.frame_end) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + CW'(1);
            if (drain_ff == CW'(DEPTH - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Channel outputs; the result payload comes straight from the head cell.
   always_comb begin
      req.ready        = 1'b0;
      rsp.valid        = 1'b0;
      rsp.sorted_value = hold_link[0].value;
      rsp.last_out     = (count_ff == CW'(1));
      rsp.overflowed   = ovf_ff;
      case (state_ff)
         ST_LOAD:  req.ready = 1'b1;
         ST_DRAIN: req.ready = 1'b0;
         ST_EMIT:  rsp.valid = 1'b1;
         default:  req.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         drain_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drain_ff <= drain_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- dv/selection_sort_frame_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the frame sorter: directed table, random frames, scoreboard.
module selection_sort_frame_top_tb;
   import ssf_pkg::*;

   localparam int SORT_DEPTH      = DEPTH_DEFAULT;
   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 4;
   localparam int RANDOM_ITEMS    = 280;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER  = 40;
   localparam int DRAIN_CYCLES    = 2 * SORT_DEPTH + 8;
   localparam int TIMEOUT_NS      = 2000000;
   localparam int DIR_ROWS        = 26;

   localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   // One sorted element as it should leave the block.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] sorted_value;
      logic                          last_out;
      logic                          overflowed;
   } sorted_result_type;

   // One row of the directed table. A row with typed set closes a frame of one
   // element and carries its own result.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          frame_end;
      logic                          typed;
      logic signed [VALUE_WIDTH-1:0] typed_value;
   } frame_row_type;

   logic clock;
   logic reset;

   ssf_req_if req_ch ();
   ssf_rsp_if rsp_ch ();

   selection_sort_frame_top #(
      .DEPTH (SORT_DEPTH)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Predictor state: the elements of the open frame and its drop flag.
   logic signed [VALUE_WIDTH-1:0] frame_store [SORT_DEPTH];
   int                            frame_count;
   logic                          frame_dropped;

   // Sorted elements still owed by the block, oldest first.
   sorted_result_type pending_sorted [$];

   int   error_count;
   int   results_seen = 0;
   int   burst_left;
   logic held_off;

   frame_row_type dir_table [DIR_ROWS];

   // Clock.
   initial begin
      clock = 1'b0;
   end

   always begin
      #(HALF_PERIOD) clock = ~clock;
   end

   // Reset is applied once at the start.
   initial begin
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit.
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   // Store one element in the predicted frame; on the closing element, queue
   // every stored element in ascending order and empty the frame.
   task automatic sort_frame_element(input logic signed [VALUE_WIDTH-1:0] v,
                                     input logic fe);
      logic signed [VALUE_WIDTH-1:0] swap;
      sorted_result_type             res;
      int                            i;
      int                            j;
      int                            pick;
      if (frame_count < SORT_DEPTH) begin
         frame_store[frame_count] = v;
         frame_count++;
      end else begin
         frame_dropped = 1'b1;
      end
      if (fe) begin
         for (i = 0; i < frame_count; i++) begin
            pick = i;
            for (j = i + 1; j < frame_count; j++) begin
               if (frame_store[j] < frame_store[pick]) begin
                  pick = j;
               end
            end
            swap              = frame_store[i];
            frame_store[i]    = frame_store[pick];
            frame_store[pick] = swap;
         end
         for (i = 0; i < frame_count; i++) begin
            res.sorted_value = frame_store[i];
            res.last_out     = (i == frame_count - 1);
            res.overflowed   = frame_dropped;
            pending_sorted.push_back(res);
         end
         frame_count   = 0;
         frame_dropped = 1'b0;
      end
   endtask

   // Offer one element in bursts with random gaps and wait for its transfer.
   task automatic offer_element(input logic signed [VALUE_WIDTH-1:0] v, input logic fe);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.value     <= v;
      req_ch.frame_end <= fe;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // Hold the input until the block has given back everything it owes.
   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_sorted.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Stimulus: directed table, then random frames.
   initial begin : stimulus
      sorted_result_type             res;
      logic signed [VALUE_WIDTH-1:0] v;
      int                            row;
      int                            frame_len;
      int                            k;
      int                            random_sent;
      logic                          paused_once;

      req_ch.valid     <= 1'b0;
      req_ch.value     <= '0;
      req_ch.frame_end <= 1'b0;
      frame_count   = 0;
      frame_dropped = 1'b0;
      error_count   = 0;
      burst_left    = 0;
      random_sent   = 0;
      paused_once   = 1'b0;

      dir_table = '{
         // Lone elements at the extremes and around zero come straight back.
         '{VAL_MIN,        1'b1, 1'b1, VAL_MIN},
         '{VAL_MAX,        1'b1, 1'b1, VAL_MAX},
         '{32'sd0,         1'b1, 1'b1, 32'sd0},
         '{-32'sd1,        1'b1, 1'b1, -32'sd1},
         // Short frame with both extremes and a repeated value.
         '{32'sd5,         1'b0, 1'b0, 32'sd0},
         '{-32'sd3,        1'b0, 1'b0, 32'sd0},
         '{VAL_MAX,        1'b0, 1'b0, 32'sd0},
         '{VAL_MIN,        1'b0, 1'b0, 32'sd0},
         '{-32'sd3,        1'b1, 1'b0, 32'sd0},
         // Full store, then a closing element that is dropped.
         '{32'sd1000,      1'b0, 1'b0, 32'sd0},
         '{-32'sd1000,     1'b0, 1'b0, 32'sd0},
         '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
         '{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0},
         '{32'sd7,         1'b0, 1'b0, 32'sd0},
         '{32'sd7,         1'b0, 1'b0, 32'sd0},
         '{-32'sd2,        1'b0, 1'b0, 32'sd0},
         '{VAL_MAX,        1'b0, 1'b0, 32'sd0},
         '{32'sh0000_0100, 1'b0, 1'b0, 32'sd0},
         '{32'shFFFF_FF00, 1'b0, 1'b0, 32'sd0},
         '{32'sd42,        1'b0, 1'b0, 32'sd0},
         '{-32'sd42,       1'b0, 1'b0, 32'sd0},
         '{32'sh1234_5678, 1'b0, 1'b0, 32'sd0},
         '{32'shEDCB_A988, 1'b0, 1'b0, 32'sd0},
         '{32'sd0,         1'b0, 1'b0, 32'sd0},
         '{VAL_MIN,        1'b0, 1'b0, 32'sd0},
         '{-32'sd5,        1'b1, 1'b0, 32'sd0}
      };

      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end

      // Directed part.
      for (row = 0; row < DIR_ROWS; row++) begin
         offer_element(dir_table[row].value, dir_table[row].frame_end);
         if (dir_table[row].typed) begin
            res.sorted_value = dir_table[row].typed_value;
            res.last_out     = 1'b1;
            res.overflowed   = 1'b0;
            pending_sorted.push_back(res);
         end else begin
            sort_frame_element(dir_table[row].value, dir_table[row].frame_end);
         end
      end
      wait_until_drained();

      // Random frames: mostly partial, some exactly full, some overflowing.
      while (random_sent < RANDOM_ITEMS) begin
         if (!paused_once && random_sent >= RANDOM_ITEMS / 2) begin
            paused_once = 1'b1;
            wait_until_drained();
         end
         case ($urandom_range(0, 9))
            0:       frame_len = 1;
            1:       frame_len = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 4);
            2:       frame_len = SORT_DEPTH;
            default: frame_len = $urandom_range(2, SORT_DEPTH - 1);
         endcase
         for (k = 0; k < frame_len; k++) begin
            case ($urandom_range(0, 5))
               0: begin
                  case ($urandom_range(0, 3))
                     0:       v = VAL_MIN;
                     1:       v = VAL_MAX;
                     2:       v = 32'sd0;
                     default: v = -32'sd1;
                  endcase
               end
               1:       v = $signed($urandom_range(0, 16)) - 32'sd8;
               default: v = $urandom;
            endcase
            offer_element(v, k == frame_len - 1);
            sort_frame_element(v, k == frame_len - 1);
            random_sent++;
         end
      end

      // Wait for the last results, then let the pipeline settle.
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_sorted.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Receiver pacing: always-ready stretches, random stalls, a fixed stall
   // pattern, and one long hold-off once results are flowing.
   initial begin : rsp_pacing
      int mode;
      int span;
      int k;
      rsp_ch.ready <= 1'b0;
      held_off = 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(8, 60);
         for (k = 0; k < span; k++) begin
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ch.ready <= (k % 4 != 3);
            endcase
            @(posedge clock);
         end
      end
   end

   // Scoreboard: each result transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      sorted_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_sorted.size() == 0) begin
            $error("unexpected result: sorted_value %0d last_out %0b overflowed %0b",
                   rsp_ch.sorted_value, rsp_ch.last_out, rsp_ch.overflowed);
            error_count++;
         end else begin
            want = pending_sorted.pop_front();
            if (rsp_ch.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      want.sorted_value, rsp_ch.sorted_value);
               error_count++;
            end
            if (rsp_ch.last_out !== want.last_out) begin
               $error("last_out: expected %0b, actual %0b", want.last_out, rsp_ch.last_out);
               error_count++;
            end
            if (rsp_ch.overflowed !== want.overflowed) begin
               $error("overflowed: expected %0b, actual %0b",
                      want.overflowed, rsp_ch.overflowed);
               error_count++;
            end
         end
      end
   end

endmodule
